// ===== rtl/grid_line_of_sight_trace_macros.svh =====
// Assertion macros for the datapath RTL of the grid line-of-sight tracer.
// They use the clock aclk and the active-low reset aresetn of the module.
`ifndef GRID_LINE_OF_SIGHT_TRACE_MACROS_SVH
`define GRID_LINE_OF_SIGHT_TRACE_MACROS_SVH

// Same-cycle implication, off during reset.
`define GLOS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in grid line-of-sight tracer");

// Next-cycle implication, off during reset.
`define GLOS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in grid line-of-sight tracer");

`endif

// ===== rtl/glos_pkg.sv =====
package glos_pkg;

    // Walk cell coordinates, signed so that a neighbour at -1 can be named.
    localparam int CELL_W = 14;
    // Crossing ratio numerator and denominator widths.
    localparam int NUM_W = 17;
    localparam int DEN_W = 16;
    // Walk parameter t, 0.32 with room for exactly one.
    localparam int T_W = 33;
    localparam logic [T_W-1:0] T_ONE = 33'h1_0000_0000;
    localparam int QUOT_W = 32;
    localparam int LEN_W = 32;
    localparam int RAD_W = 64;
    localparam int ACC_W = 64;
    localparam int OUT_W = 40;
    localparam int LEN_EXTRA_BITS = 15;
    localparam int COST_FRAC_BITS = 8;
    localparam int VIS_W = 11;

    // Stream payload widths.
    localparam int IN_DW = 104;
    localparam int OUT_DW = 48;

    // Diagonal policy codes.
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_CUT = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_GOAL,
        S_SQ,
        S_SQRT,
        S_TOP,
        S_CUR,
        S_LEFT,
        S_LOW,
        S_BRANCH,
        S_CMP,
        S_DSTART,
        S_DIV,
        S_SEG,
        S_WGT,
        S_ACC,
        S_CX,
        S_CY,
        S_STEP,
        S_FAIL,
        S_FINAL,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        RS_GOAL,
        RS_CUR,
        RS_LEFT,
        RS_LOW,
        RS_CX,
        RS_CY
    } rd_sel_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] width;
        logic [8:0] height;
    } cfg_t;

    typedef struct packed {
        logic    write_en;
        logic    load_query;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    sq_a;
        logic    sq_b;
        logic    sqrt_start;
        logic    cost_cap;
        logic    mul_en;
        logic    cmp_en;
        logic    div_start;
        logic    seg_en;
        logic    wgt_en;
        logic    acc_en;
        logic    step_en;
        logic    res_pass;
        logic    res_fail;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic query_ok;
        logic rd_clear;
        logic need_left;
        logic need_low;
        logic strict;
        logic at_goal;
        logic tie;
        logic limit_hit;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } st_t;

endpackage

// ===== rtl/glos_sqrt.sv =====
module glos_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [glos_pkg::RAD_W-1:0]   radicand,
    output logic [glos_pkg::LEN_W-1:0]   root,
    output logic                         done
);
    import glos_pkg::*;

    localparam int REM_W = LEN_W + 3;
    localparam int CNT_W = $clog2(LEN_W + 1);

    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [LEN_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // Bring down two radicand bits a step.
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(LEN_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[LEN_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = !busy_reg;

endmodule

// ===== rtl/glos_div.sv =====
module glos_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [glos_pkg::NUM_W-1:0]    num,
    input  logic [glos_pkg::DEN_W-1:0]    den,
    output logic [glos_pkg::QUOT_W-1:0]   quot,
    output logic                          done
);
    import glos_pkg::*;

    localparam int REM_W = NUM_W + 1;
    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [REM_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [REM_W-1:0]  rem_sh;
    logic              ge;

    // Restoring division, one quotient bit a step.
    assign rem_sh = {rem_reg[REM_W-2:0], 1'b0};
    assign ge     = rem_sh >= REM_W'(den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUOT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= REM_W'(num);
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? rem_sh - REM_W'(den_reg) : rem_sh;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    assign quot = quot_reg;
    assign done = !busy_reg;

endmodule

// ===== rtl/glos_ctrl.sv =====
module glos_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            opcode,
    output logic            s_tready,
    input  glos_pkg::st_t   st,
    output glos_pkg::cmd_t  cmd
);
    import glos_pkg::*;

    localparam logic OPC_TRACE = 1'b1;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RS_CUR;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (opcode == OPC_TRACE) begin
                        cmd.load_query = 1'b1;
                        state_next     = S_CHECK;
                    end else begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                cmd.sq_a = 1'b1;
                if (!st.query_ok) begin
                    state_next = S_FAIL;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_GOAL;
                    state_next = S_GOAL;
                end
            end
            S_GOAL: begin
                cmd.sq_b   = 1'b1;
                state_next = st.rd_clear ? S_SQ : S_FAIL;
            end
            S_SQ: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT: begin
                if (st.sqrt_done) begin
                    state_next = S_TOP;
                end
            end
            S_TOP: begin
                if (st.limit_hit) begin
                    state_next = S_FAIL;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_CUR;
                    state_next = S_CUR;
                end
            end
            S_CUR: begin
                cmd.cost_cap = 1'b1;
                if (!st.rd_clear) begin
                    state_next = S_FAIL;
                end else if (st.need_left) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_LEFT;
                    state_next = S_LEFT;
                end else if (st.need_low) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_LOW;
                    state_next = S_LOW;
                end else begin
                    state_next = S_BRANCH;
                end
            end
            S_LEFT: begin
                if (!st.rd_clear) begin
                    state_next = S_FAIL;
                end else if (st.need_low) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_LOW;
                    state_next = S_LOW;
                end else begin
                    state_next = S_BRANCH;
                end
            end
            S_LOW: begin
                state_next = st.rd_clear ? S_BRANCH : S_FAIL;
            end
            S_BRANCH: begin
                if (st.at_goal) begin
                    state_next = S_SEG;
                end else begin
                    cmd.mul_en = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.cmp_en = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (st.div_done) begin
                    state_next = S_SEG;
                end
            end
            S_SEG: begin
                cmd.seg_en = 1'b1;
                state_next = S_WGT;
            end
            S_WGT: begin
                cmd.wgt_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc_en = 1'b1;
                if (st.at_goal) begin
                    state_next = S_FINAL;
                end else if (st.tie && st.strict) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_CX;
                    state_next = S_CX;
                end else begin
                    state_next = S_STEP;
                end
            end
            S_CX: begin
                if (!st.rd_clear) begin
                    state_next = S_FAIL;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_CY;
                    state_next = S_CY;
                end
            end
            S_CY: begin
                state_next = st.rd_clear ? S_STEP : S_FAIL;
            end
            S_STEP: begin
                cmd.step_en = 1'b1;
                state_next  = S_TOP;
            end
            S_FAIL: begin
                cmd.res_fail = 1'b1;
                state_next   = S_OUT;
            end
            S_FINAL: begin
                cmd.res_pass = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/glos_dp.sv =====
`include "grid_line_of_sight_trace_macros.svh"

module glos_dp #(
    parameter int MAX_COLS        = 256,
    parameter int MAX_ROWS        = 256,
    parameter int COORD_FRAC_BITS = 8,
    parameter int COST_BITS       = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  glos_pkg::cfg_t                cfg,
    input  glos_pkg::cmd_t                cmd,
    output glos_pkg::st_t                 st,
    input  logic [glos_pkg::IN_DW-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [glos_pkg::OUT_DW-1:0]   m_tdata
);
    import glos_pkg::*;

    localparam int CB    = $clog2(MAX_COLS);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int AW    = CB + RB;
    localparam int DW    = COST_BITS + 1;
    localparam int LIM_W = (9 + COORD_FRAC_BITS > 16) ? 9 + COORD_FRAC_BITS : 16;
    localparam int OUT_SHIFT = COORD_FRAC_BITS + LEN_EXTRA_BITS + COST_FRAC_BITS - 16;
    localparam int PROD_W = DEN_W + NUM_W;
    localparam int WP_W   = LEN_W + COST_BITS;
    localparam logic signed [CELL_W-1:0] C_ONE = CELL_W'(1);

    // Input payload fields.
    logic [7:0]  in_col;
    logic [7:0]  in_row;
    logic        in_blocked;
    logic [15:0] in_cost;
    logic [15:0] in_sx;
    logic [15:0] in_sy;
    logic [15:0] in_gx;
    logic [15:0] in_gy;

    assign in_col     = s_tdata[7:0];
    assign in_row     = s_tdata[15:8];
    assign in_blocked = s_tdata[16];
    assign in_cost    = s_tdata[32:17];
    assign in_sx      = s_tdata[48:33];
    assign in_sy      = s_tdata[64:49];
    assign in_gx      = s_tdata[80:65];
    assign in_gy      = s_tdata[96:81];

    // Cell store.
    logic [DW-1:0] mem [0:(1 << AW)-1];
    logic [DW-1:0] rd_data_reg;
    logic          rd_in_grid_reg;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_ok;
    logic [CELL_W-1:0] wr_c;
    logic [CELL_W-1:0] wr_r;

    // Query state.
    logic [15:0] sx_reg, sy_reg, adx_reg, ady_reg;
    logic        xpos_reg, ypos_reg, xneg_reg, yneg_reg;
    logic        on_vert_reg, on_horz_reg, query_ok_reg;
    logic signed [CELL_W-1:0] x_reg, y_reg, goal_x_reg, goal_y_reg;
    logic signed [CELL_W-1:0] stepx_reg, stepy_reg;
    logic [31:0] sqa_reg, sqb_reg;
    logic [T_W-1:0] prev_t_reg;
    logic [VIS_W-1:0] visited_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [PROD_W-1:0] pa_reg, pb_reg;
    logic cross_x_reg, cross_y_reg, triv_reg;
    logic [NUM_W-1:0] sel_num_reg;
    logic [DEN_W-1:0] sel_den_reg;
    logic [LEN_W-1:0] seg_reg;
    logic [ACC_W-1:0] wgt_reg, acc_reg;
    logic             res_clear_reg;
    logic [OUT_W-1:0] res_len_reg;
    logic             m_tvalid_reg;
    logic [OUT_DW-1:0] m_tdata_reg;

    // Combinational helpers.
    logic [LIM_W-1:0] wlim, hlim;
    logic             bounds_ok, diag_bad;
    logic signed [CELL_W-1:0] rx, ry;
    logic             rd_in_grid;
    logic [31:0]      sx32, sy32, xhi, xlo, yhi, ylo;
    logic [NUM_W-1:0] nx_num, ny_num;
    logic             nx_inf, ny_inf, cx, cy;
    logic [QUOT_W-1:0] quot;
    logic [LEN_W-1:0] len;
    logic [T_W-1:0]   next_t, dt;
    logic [63:0]      seg_prod;
    logic [WP_W-1:0]  wprod;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_sh;
    logic [32:0]      sq_sum;
    logic [VIS_W-1:0] limit;
    logic             div_done, sqrt_done;

    // Writes outside the store are dropped.
    assign wr_c    = CELL_W'(in_col);
    assign wr_r    = CELL_W'(in_row);
    assign wr_ok   = (32'(in_col) < MAX_COLS) && (32'(in_row) < MAX_ROWS);
    assign wr_addr = {wr_r[RB-1:0], wr_c[CB-1:0]};

    always_comb begin
        case (cmd.rd_sel)
            RS_GOAL: begin rx = goal_x_reg;          ry = goal_y_reg;          end
            RS_CUR:  begin rx = x_reg;               ry = y_reg;               end
            RS_LEFT: begin rx = x_reg - C_ONE;       ry = y_reg;               end
            RS_LOW:  begin rx = x_reg;               ry = y_reg - C_ONE;       end
            RS_CX:   begin rx = x_reg + stepx_reg;   ry = y_reg;               end
            RS_CY:   begin rx = x_reg;               ry = y_reg + stepy_reg;   end
            default: begin rx = x_reg;               ry = y_reg;               end
        endcase
    end

    assign rd_in_grid = (rx >= 0) && (ry >= 0) &&
                        (rx < $signed(CELL_W'(cfg.width))) &&
                        (ry < $signed(CELL_W'(cfg.height)));
    assign rd_addr = {ry[RB-1:0], rx[CB-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.write_en && wr_ok) begin
            mem[wr_addr] <= {in_blocked, COST_BITS'(in_cost)};
        end
        if (cmd.rd_en) begin
            rd_data_reg    <= mem[rd_addr];
            rd_in_grid_reg <= rd_in_grid;
        end
    end

    // Query admission: endpoints inside the grid, diagonal policy.
    assign wlim      = LIM_W'(cfg.width) << COORD_FRAC_BITS;
    assign hlim      = LIM_W'(cfg.height) << COORD_FRAC_BITS;
    assign bounds_ok = (LIM_W'(in_sx) < wlim) && (LIM_W'(in_gx) < wlim) &&
                       (LIM_W'(in_sy) < hlim) && (LIM_W'(in_gy) < hlim);
    assign diag_bad  = (cfg.mode == MODE_OFF) && (in_gx != in_sx) && (in_gy != in_sy);

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            sx_reg       <= in_sx;
            sy_reg       <= in_sy;
            xpos_reg     <= in_gx > in_sx;
            xneg_reg     <= in_gx < in_sx;
            ypos_reg     <= in_gy > in_sy;
            yneg_reg     <= in_gy < in_sy;
            adx_reg      <= (in_gx > in_sx) ? in_gx - in_sx : in_sx - in_gx;
            ady_reg      <= (in_gy > in_sy) ? in_gy - in_sy : in_sy - in_gy;
            stepx_reg    <= (in_gx > in_sx) ? C_ONE : ((in_gx < in_sx) ? -C_ONE : '0);
            stepy_reg    <= (in_gy > in_sy) ? C_ONE : ((in_gy < in_sy) ? -C_ONE : '0);
            on_vert_reg  <= (in_gx == in_sx) && (in_sx[COORD_FRAC_BITS-1:0] == '0);
            on_horz_reg  <= (in_gy == in_sy) && (in_sy[COORD_FRAC_BITS-1:0] == '0);
            query_ok_reg <= bounds_ok && !diag_bad;
            x_reg        <= $signed(CELL_W'(in_sx >> COORD_FRAC_BITS));
            y_reg        <= $signed(CELL_W'(in_sy >> COORD_FRAC_BITS));
            goal_x_reg   <= $signed(CELL_W'(in_gx >> COORD_FRAC_BITS));
            goal_y_reg   <= $signed(CELL_W'(in_gy >> COORD_FRAC_BITS));
            prev_t_reg   <= '0;
            acc_reg      <= '0;
            visited_reg  <= '0;
        end else begin
            if (cmd.step_en) begin
                if (cross_x_reg) begin
                    x_reg <= x_reg + stepx_reg;
                end
                if (cross_y_reg) begin
                    y_reg <= y_reg + stepy_reg;
                end
                prev_t_reg  <= next_t;
                visited_reg <= visited_reg + 1'b1;
            end
            if (cmd.acc_en) begin
                acc_reg <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            end
        end
    end

    // Squared length, one multiplier a cycle.
    always_ff @(posedge aclk) begin
        if (cmd.sq_a) begin
            sqa_reg <= adx_reg * adx_reg;
        end
        if (cmd.sq_b) begin
            sqb_reg <= ady_reg * ady_reg;
        end
    end

    assign sq_sum = 33'(sqa_reg) + 33'(sqb_reg);

    glos_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (RAD_W'(sq_sum) << (2 * LEN_EXTRA_BITS)),
        .root     (len),
        .done     (sqrt_done)
    );

    // Distance to the next column and row boundaries.
    assign sx32 = 32'(sx_reg);
    assign sy32 = 32'(sy_reg);
    assign xlo  = 32'(unsigned'(x_reg)) << COORD_FRAC_BITS;
    assign xhi  = 32'(unsigned'(x_reg + C_ONE)) << COORD_FRAC_BITS;
    assign ylo  = 32'(unsigned'(y_reg)) << COORD_FRAC_BITS;
    assign yhi  = 32'(unsigned'(y_reg + C_ONE)) << COORD_FRAC_BITS;

    always_comb begin
        if (xpos_reg) begin
            nx_num = NUM_W'(xhi - sx32);
        end else if (xneg_reg && (sx32 > xlo)) begin
            nx_num = NUM_W'(sx32 - xlo);
        end else begin
            nx_num = '0;
        end
        if (ypos_reg) begin
            ny_num = NUM_W'(yhi - sy32);
        end else if (yneg_reg && (sy32 > ylo)) begin
            ny_num = NUM_W'(sy32 - ylo);
        end else begin
            ny_num = '0;
        end
    end

    // A zero span means the crossing never comes.
    assign nx_inf = adx_reg == '0;
    assign ny_inf = ady_reg == '0;
    assign cx = nx_inf ? ny_inf : (ny_inf ? 1'b1 : (pa_reg <= pb_reg));
    assign cy = ny_inf ? nx_inf : (nx_inf ? 1'b1 : (pb_reg <= pa_reg));

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            pa_reg <= nx_num * ady_reg;
            pb_reg <= ny_num * adx_reg;
        end
        if (cmd.cmp_en) begin
            cross_x_reg <= cx;
            cross_y_reg <= cy;
            sel_num_reg <= cx ? nx_num : ny_num;
            sel_den_reg <= cx ? adx_reg : ady_reg;
        end
        if (cmd.div_start) begin
            triv_reg <= (sel_den_reg == '0) || (NUM_W'(sel_den_reg) <= sel_num_reg);
        end
    end

    glos_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (sel_num_reg),
        .den     (sel_den_reg),
        .quot    (quot),
        .done    (div_done)
    );

    // Clip the crossing to t = 1.
    assign next_t = triv_reg ? T_ONE : T_W'(quot);
    assign dt = st.at_goal ? (T_ONE - prev_t_reg) :
                ((next_t > prev_t_reg) ? next_t - prev_t_reg : '0);

    assign seg_prod = dt[QUOT_W-1:0] * len;
    assign wprod    = seg_reg * cost_reg;
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, wgt_reg};
    assign acc_sh   = acc_reg >> OUT_SHIFT;

    always_ff @(posedge aclk) begin
        if (cmd.cost_cap) begin
            cost_reg <= rd_data_reg[COST_BITS-1:0];
        end
        if (cmd.seg_en) begin
            seg_reg <= (dt == T_ONE) ? len : seg_prod[63:32];
        end
        if (cmd.wgt_en) begin
            wgt_reg <= ACC_W'(wprod);
        end
        if (cmd.res_pass) begin
            res_clear_reg <= 1'b1;
            res_len_reg   <= (|acc_sh[ACC_W-1:OUT_W]) ? '1 : acc_sh[OUT_W-1:0];
        end else if (cmd.res_fail) begin
            res_clear_reg <= 1'b0;
            res_len_reg   <= '0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= OUT_DW'({res_len_reg, res_clear_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign limit = VIS_W'(cfg.width) + VIS_W'(cfg.height) + VIS_W'(2);

    always_comb begin
        st           = '0;
        st.query_ok  = query_ok_reg;
        st.rd_clear  = rd_in_grid_reg && !rd_data_reg[COST_BITS];
        st.strict    = cfg.mode != MODE_CUT;
        st.need_left = st.strict && on_vert_reg && (x_reg > 0);
        st.need_low  = st.strict && on_horz_reg && (y_reg > 0);
        st.at_goal   = (x_reg == goal_x_reg) && (y_reg == goal_y_reg);
        st.tie       = cross_x_reg && cross_y_reg;
        st.limit_hit = visited_reg == limit;
        st.sqrt_done = sqrt_done;
        st.div_done  = div_done;
        st.out_free  = !m_tvalid_reg || m_tready;
    end

    `GLOS_ASSERT_IMP(a_step_limit, cmd.step_en, visited_reg < limit)
    `GLOS_ASSERT_IMP(a_goal_nodiv, cmd.div_start, !st.at_goal)
    `GLOS_ASSERT_IMP(a_fail_zero, m_tvalid_reg && !m_tdata_reg[0], m_tdata_reg[OUT_W:1] == '0)
    `GLOS_ASSERT_NXT(a_out_load, cmd.out_load, m_tvalid_reg)

endmodule

// ===== rtl/grid_line_of_sight_trace.sv =====
// Grid line-of-sight tracer. A write item (tuser 0) stores one cell's blocked
// bit and 8.8 cost. A trace item (tuser 1) walks the segment between two 8.8
// points cell by cell and returns one result: whether the segment is clear
// under the diagonal policy and its cost-weighted length in 24.16, zero when
// not clear. A trace first finds the length with the 32-step square root,
// then for each cell crossed runs the 32-step divider that places the next
// boundary crossing, plus one read per boundary-neighbour or corner check,
// and ends with the goal cell. Queries that fail admission skip the square
// root and the walk. The cell store has one port, so every cell and neighbour
// check is one read. The store has no reset: trace only over cells that have
// been written.
module grid_line_of_sight_trace #(
    parameter int MAX_COLS        = 256,
    parameter int MAX_ROWS        = 256,
    parameter int COORD_FRAC_BITS = 8,
    parameter int COST_BITS       = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, lowest bit up: write_col[7:0], write_row[15:8],
    // write_blocked[16], write_cost[32:17], start_px[48:33],
    // start_py[64:49], goal_px[80:65], goal_py[96:81], zero fill.
    input  logic [glos_pkg::IN_DW-1:0]    s_tdata,
    // s_tuser: opcode[0].
    input  logic [0:0]                    s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, lowest bit up: path_clear[0], weighted_length[40:1], zero fill.
    output logic [glos_pkg::OUT_DW-1:0]   m_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import glos_pkg::*;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    logic [1:0] mode_reg;
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic       cfg_wr;
    cfg_t       cfg;
    cmd_t       cmd;
    st_t        st;

    // Register writes complete in the access phase; pready is held high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 2'd1;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MODE:   mode_reg   <= pwdata[1:0];
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = 32'(mode_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Clip the grid size to the store; all checks below use the clipped size.
    assign cfg.mode   = mode_reg;
    assign cfg.width  = (32'(width_reg) > MAX_COLS) ? 9'(MAX_COLS) : width_reg;
    assign cfg.height = (32'(height_reg) > MAX_ROWS) ? 9'(MAX_ROWS) : height_reg;

    // Sequencer: admits requests, steps the walk, hands results to the output.
    glos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser[0]),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: cell store, square root, crossing divider, accumulator.
    glos_dp #(
        .MAX_COLS        (MAX_COLS),
        .MAX_ROWS        (MAX_ROWS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .COST_BITS       (COST_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/grid_line_of_sight_trace_test.sv =====
`timescale 1ns / 1ps

module grid_line_of_sight_trace_test;
    import glos_pkg::*;

    typedef longint unsigned u64;

    localparam bit OP_WRITE = 1'b0;
    localparam bit OP_TRACE = 1'b1;
    localparam logic [3:0] REG_MODE   = 4'd0;
    localparam logic [3:0] REG_WIDTH  = 4'd4;
    localparam logic [3:0] REG_HEIGHT = 4'd8;
    localparam logic [1:0] MODE_STRICT = 2'd1;
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam u64 LEN_MAX = (64'd1 << 40) - 64'd1;
    localparam u64 T_FULL  = 64'd1 << 32;
    localparam u64 ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        bit        op;
        bit [7:0]  col;
        bit [7:0]  row;
        bit        blk;
        bit [15:0] cost;
        bit [15:0] sx;
        bit [15:0] sy;
        bit [15:0] gx;
        bit [15:0] gy;
    } request_t;

    typedef struct {
        bit        clear;
        bit [39:0] len;
    } verdict_t;

    typedef struct {
        request_t rq;
        bit       fixed;
        verdict_t want;
    } step_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    grid_line_of_sight_trace u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the block: cell store, registers, and the verdicts still owed.
    bit [16:0]   shadow_cells [0:65535];
    logic [1:0]  shadow_mode;
    logic [8:0]  shadow_width;
    logic [8:0]  shadow_height;
    verdict_t    verdict_q [$];
    step_row_t   step_table [$];

    int  error_count;
    int  trace_count;
    int  write_count;
    int  clear_count;
    bit  idle_on;
    bit  hold_req;

    initial begin
        aclk = 1'b0;
    end
    always #6 aclk = ~aclk;

    // Guard against a hung block.
    initial begin
        #60_000_000;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Queue a verdict owed by the block.
    function automatic void owe_verdict(verdict_t v);
        verdict_q = {verdict_q, v};
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(request_t rq, bit fixed, verdict_t want);
        step_row_t row;
        row.rq = rq;
        row.fixed = fixed;
        row.want = want;
        step_table = {step_table, row};
    endfunction

    function automatic int eff_w();
        return (shadow_width > 9'd256) ? 256 : int'(shadow_width);
    endfunction

    function automatic int eff_h();
        return (shadow_height > 9'd256) ? 256 : int'(shadow_height);
    endfunction

    // Off-grid cells count as blocked and are never read.
    function automatic bit cell_free(int cx, int cy);
        if (cx < 0 || cy < 0 || cx >= eff_w() || cy >= eff_h())
            return 1'b0;
        return !shadow_cells[cy * 256 + cx][16];
    endfunction

    function automatic u64 root_floor(u64 v);
        u64 res;
        u64 b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Compare crossing ratios; a zero denominator stands for infinity.
    function automatic bit ratio_not_above(u64 an, u64 ad, u64 bn, u64 bd);
        if (ad == 0)
            return bd == 0;
        if (bd == 0)
            return 1'b1;
        return an * bd <= bn * ad;
    endfunction

    function automatic u64 ratio_as_t(u64 n, u64 d);
        if (d == 0 || n >= d)
            return T_FULL;
        return (n << 32) / d;
    endfunction

    function automatic u64 add_sat(u64 a, u64 b);
        return (a > ALL_ONES - b) ? ALL_ONES : a + b;
    endfunction

    function automatic u64 cell_weight(u64 dt, u64 len, int cx, int cy);
        u64 seg;
        u64 c;
        seg = (dt * len) >> 32;
        c = u64'(shadow_cells[cy * 256 + cx][15:0]);
        if (c != 0 && seg > ALL_ONES / c)
            return ALL_ONES;
        return seg * c;
    endfunction

    // Walk the segment cell by cell and work out clearance and weighted length.
    function automatic verdict_t trace_segment(request_t r);
        verdict_t v;
        int  w, h, x, y, tx, ty, stx, sty;
        u64  sx, sy, gx, gy, adx, ady, len, prev_t, acc, next_t, dt, lim, b;
        u64  nxn, nxd, nyn, nyd;
        bit  strict, on_vert, on_horz, cx, cy;
        v.clear = 1'b0;
        v.len = '0;
        w = eff_w();
        h = eff_h();
        sx = r.sx;
        sy = r.sy;
        gx = r.gx;
        gy = r.gy;
        if (!(sx < (u64'(w) << 8) && gx < (u64'(w) << 8) &&
              sy < (u64'(h) << 8) && gy < (u64'(h) << 8)))
            return v;
        x = int'(sx >> 8);
        y = int'(sy >> 8);
        tx = int'(gx >> 8);
        ty = int'(gy >> 8);
        stx = (gx > sx) ? 1 : ((gx < sx) ? -1 : 0);
        sty = (gy > sy) ? 1 : ((gy < sy) ? -1 : 0);
        adx = (gx > sx) ? gx - sx : sx - gx;
        ady = (gy > sy) ? gy - sy : sy - gy;
        if (shadow_mode == MODE_OFF && adx != 0 && ady != 0)
            return v;
        strict = shadow_mode != MODE_CUT;
        on_vert = adx == 0 && sx[7:0] == 0;
        on_horz = ady == 0 && sy[7:0] == 0;
        if (!cell_free(tx, ty))
            return v;
        len = root_floor((adx * adx + ady * ady) << 30);
        prev_t = 0;
        acc = 0;
        lim = u64'(w) + u64'(h) + 2;
        for (u64 k = 0; k < lim; k++) begin
            if (!cell_free(x, y) ||
                (strict && on_vert && x > 0 && !cell_free(x - 1, y)) ||
                (strict && on_horz && y > 0 && !cell_free(x, y - 1)))
                return v;
            if (x == tx && y == ty) begin
                dt = (prev_t < T_FULL) ? T_FULL - prev_t : 0;
                acc = add_sat(acc, cell_weight(dt, len, x, y));
                acc = acc >> 15;
                v.clear = 1'b1;
                v.len = (acc > LEN_MAX) ? LEN_MAX[39:0] : acc[39:0];
                return v;
            end
            nxn = 0; nxd = 0; nyn = 0; nyd = 0;
            if (stx > 0) begin
                nxn = (u64'(x + 1) << 8) - sx;
                nxd = adx;
            end else if (stx < 0) begin
                b = u64'(x) << 8;
                nxn = (sx > b) ? sx - b : 0;
                nxd = adx;
            end
            if (sty > 0) begin
                nyn = (u64'(y + 1) << 8) - sy;
                nyd = ady;
            end else if (sty < 0) begin
                b = u64'(y) << 8;
                nyn = (sy > b) ? sy - b : 0;
                nyd = ady;
            end
            cx = ratio_not_above(nxn, nxd, nyn, nyd);
            cy = ratio_not_above(nyn, nyd, nxn, nxd);
            next_t = cx ? ratio_as_t(nxn, nxd) : ratio_as_t(nyn, nyd);
            dt = (next_t > prev_t) ? next_t - prev_t : 0;
            acc = add_sat(acc, cell_weight(dt, len, x, y));
            // At an exact corner in strict mode both side cells must be free.
            if (cx && cy && strict && (!cell_free(x + stx, y) || !cell_free(x, y + sty)))
                return v;
            if (cx)
                x = x + stx;
            if (cy)
                y = y + sty;
            prev_t = next_t;
        end
        return v;
    endfunction

    function automatic request_t write_req(int c, int r, bit blk, bit [15:0] cost);
        request_t q;
        q = '{default: '0};
        q.op = OP_WRITE;
        q.col = c[7:0];
        q.row = r[7:0];
        q.blk = blk;
        q.cost = cost;
        return q;
    endfunction

    function automatic request_t trace_req(bit [15:0] sx, bit [15:0] sy,
                                           bit [15:0] gx, bit [15:0] gy);
        request_t q;
        q = '{default: '0};
        q.op = OP_TRACE;
        q.sx = sx;
        q.sy = sy;
        q.gx = gx;
        q.gy = gy;
        return q;
    endfunction

    function automatic bit [15:0] pick_coord(int base, int span);
        bit [7:0] frac;
        frac = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        return {8'(base + $urandom_range(0, span - 1)), frac};
    endfunction

    // Keep every walk inside a block of written cells: the low block 0..5,
    // or the high block 251..255 whose left and lower neighbours are written.
    function automatic request_t pick_trace();
        request_t q;
        int bx, by, spx, spy, d, lo, hi, kind, w, h;
        w = eff_w();
        h = eff_h();
        if (w == 0 || h == 0)
            return trace_req(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if (w >= 256 && h >= 256 && $urandom_range(0, 1) == 1) begin
            bx = 251; by = 251; spx = 5; spy = 5;
        end else begin
            bx = 0; by = 0;
            spx = (w < 6) ? w : 6;
            spy = (h < 6) ? h : 6;
        end
        q = trace_req(pick_coord(bx, spx), pick_coord(by, spy),
                      pick_coord(bx, spx), pick_coord(by, spy));
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            q.gx = q.sx;
        end else if (kind < 4) begin
            q.gy = q.sy;
        end else if (kind == 4) begin
            d = $urandom_range(1, 4) * 256 + (($urandom_range(0, 1) == 1) ? 0 : 128);
            lo = bx * 256;
            hi = (bx + spx) * 256 - 1;
            if (int'(q.sx) + d <= hi) q.gx = 16'(int'(q.sx) + d);
            else if (int'(q.sx) - d >= lo) q.gx = 16'(int'(q.sx) - d);
            lo = by * 256;
            hi = (by + spy) * 256 - 1;
            if (q.gx != q.sx && int'(q.sy) + d <= hi) q.gy = 16'(int'(q.sy) + d);
            else if (q.gx != q.sx && int'(q.sy) - d >= lo) q.gy = 16'(int'(q.sy) - d);
        end else if (kind == 5) begin
            // Push one endpoint off the grid where the grid leaves room.
            if (w < 256) q.gx = 16'($urandom_range(w * 256, 65535));
            else if (h < 256) q.sy = 16'($urandom_range(h * 256, 65535));
        end
        return q;
    endfunction

    // Offer one request, idling first now and then; predict once it is taken.
    task automatic send(request_t r, bit fixed, verdict_t want);
        int n;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {7'd0, r.gy, r.gx, r.sy, r.sx, r.cost, r.blk, r.row, r.col};
        do @(posedge aclk); while (!s_tready);
        if (r.op == OP_WRITE) begin
            shadow_cells[int'(r.row) * 256 + int'(r.col)] = {r.blk, r.cost};
            write_count++;
        end else begin
            owe_verdict(fixed ? want : trace_segment(r));
            trace_count++;
        end
    endtask

    task automatic send_pred(request_t r);
        send(r, 1'b0, '{1'b0, 40'd0});
    endtask

    // Hold the input until every verdict is back and the walk has wound down.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic reg_write(logic [3:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_MODE:   shadow_mode = value[1:0];
            REG_WIDTH:  shadow_width = value[8:0];
            REG_HEIGHT: shadow_height = value[8:0];
            default: ;
        endcase
    endtask

    // Result receiver: random back-pressure, and one long hold-off on demand.
    initial begin
        int n;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (2000) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result with the oldest verdict owed.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, actual clear %0b length %0h",
                         $time, m_tdata[0], m_tdata[40:1]);
                error_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.clear) begin
                    $display("%0t: path_clear expected %0b actual %0b",
                             $time, want.clear, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[40:1] !== want.len) begin
                    $display("%0t: weighted_length expected %0h actual %0h",
                             $time, want.len, m_tdata[40:1]);
                    error_count++;
                end
                if (want.clear)
                    clear_count++;
            end
        end
    end

    initial begin
        logic [1:0] modes [8];
        logic [8:0] widths [8];
        logic [8:0] heights [8];
        int counts [8];
        request_t r;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= '0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        error_count = 0;
        trace_count = 0;
        write_count = 0;
        clear_count = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        shadow_mode = MODE_STRICT;
        shadow_width = 9'd256;
        shadow_height = 9'd256;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill both cell blocks, free, with random costs.
        for (int c = 0; c < 6; c++)
            for (int rr = 0; rr < 6; rr++) begin
                send_pred(write_req(c, rr, 1'b0, 16'($urandom)));
                send_pred(write_req(250 + c, 250 + rr, 1'b0, 16'($urandom)));
            end

        // Directed table, reset configuration.
        add_row(write_req(0, 0, 1'b0, 16'h0100), 1'b0, '{1'b0, 40'd0});
        add_row(trace_req(16'h0080, 16'h0080, 16'h0080, 16'h0080), 1'b1,
                '{1'b1, 40'd0});
        add_row(trace_req(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1,
                '{1'b1, 40'd0});
        add_row(write_req(255, 255, 1'b1, 16'hFFFF), 1'b0, '{1'b0, 40'd0});
        add_row(trace_req(16'hFD80, 16'hFF80, 16'hFF80, 16'hFF80), 1'b1,
                '{1'b0, 40'd0});
        add_row(write_req(255, 255, 1'b0, 16'hFFFF), 1'b0, '{1'b0, 40'd0});
        add_row(trace_req(16'hFFFF, 16'hFFFF, 16'hFB00, 16'hFB00), 1'b0,
                '{1'b0, 40'd0});
        add_row(trace_req(16'hFB00, 16'hFB00, 16'hFFFF, 16'hFFFF), 1'b0,
                '{1'b0, 40'd0});
        add_row(write_req(1, 0, 1'b0, 16'h0100), 1'b0, '{1'b0, 40'd0});
        add_row(trace_req(16'h0000, 16'h0080, 16'h01FF, 16'h0080), 1'b0,
                '{1'b0, 40'd0});
        // Vertical along a cell boundary, then horizontal along one.
        add_row(trace_req(16'h0100, 16'h0033, 16'h0100, 16'h03B3), 1'b0,
                '{1'b0, 40'd0});
        add_row(trace_req(16'h0040, 16'h0200, 16'h0440, 16'h0200), 1'b0,
                '{1'b0, 40'd0});
        // Exact corners, clear and then with a side cell blocked.
        add_row(trace_req(16'h0080, 16'h0080, 16'h0280, 16'h0280), 1'b0,
                '{1'b0, 40'd0});
        add_row(write_req(1, 0, 1'b1, 16'h0100), 1'b0, '{1'b0, 40'd0});
        add_row(trace_req(16'h0080, 16'h0080, 16'h0280, 16'h0280), 1'b0,
                '{1'b0, 40'd0});
        add_row(trace_req(16'h0100, 16'h0300, 16'h0100, 16'h0000), 1'b0,
                '{1'b0, 40'd0});
        add_row(write_req(1, 0, 1'b0, 16'hFFFF), 1'b0, '{1'b0, 40'd0});
        add_row(trace_req(16'h05FF, 16'h0000, 16'h0000, 16'h05FF), 1'b0,
                '{1'b0, 40'd0});
        foreach (step_table[i])
            send(step_table[i].rq, step_table[i].fixed, step_table[i].want);
        drain();

        // Phases: mode, width, height, items. Extremes and clipped sizes included.
        modes   = '{MODE_STRICT, MODE_OFF, MODE_CUT, MODE_SPARE,
                    MODE_CUT, MODE_STRICT, MODE_OFF, MODE_STRICT};
        widths  = '{9'd6, 9'd6, 9'd6, 9'd5, 9'd256, 9'd1, 9'd511, 9'd6};
        heights = '{9'd6, 9'd6, 9'd6, 9'd3, 9'd256, 9'd6, 9'd300, 9'd6};
        counts  = '{70, 60, 70, 50, 70, 30, 60, 60};
        for (int p = 0; p < 8; p++) begin
            drain();
            reg_write(REG_MODE, 32'(modes[p]));
            reg_write(REG_WIDTH, 32'(widths[p]));
            reg_write(REG_HEIGHT, 32'(heights[p]));
            // Last phase runs flat out; the second stalls the receiver for long.
            idle_on = (p != 7);
            if (p == 1)
                hold_req = 1'b1;
            for (int i = 0; i < counts[p]; i++) begin
                if ($urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 4) == 0)
                        r = write_req($urandom_range(0, 255), $urandom_range(0, 255),
                                      1'($urandom), 16'($urandom));
                    else if ($urandom_range(0, 1) == 0)
                        r = write_req($urandom_range(0, 5), $urandom_range(0, 5),
                                      $urandom_range(0, 4) == 0, 16'($urandom));
                    else
                        r = write_req($urandom_range(250, 255), $urandom_range(250, 255),
                                      $urandom_range(0, 4) == 0, 16'($urandom));
                end else begin
                    r = pick_trace();
                end
                send_pred(r);
            end
        end
        // Zero grid size rejects everything.
        drain();
        reg_write(REG_WIDTH, 32'd0);
        repeat (4) send_pred(pick_trace());
        drain();
        repeat (100) @(posedge aclk);

        $display("Covered %0d traces (%0d clear) and %0d cell writes", trace_count,
                 clear_count, write_count);
        $display("over all diagonal modes, grid sizes from zero to clipped, with stalls");
        if (error_count == 0 && verdict_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/glos_pkg.sv
rtl/glos_sqrt.sv
rtl/glos_div.sv
rtl/glos_ctrl.sv
rtl/glos_dp.sv
rtl/grid_line_of_sight_trace.sv
bench/grid_line_of_sight_trace_test.sv
